FILE: sv/tpa_pkg.sv
// Shared codes, defaults and controller/datapath interface types for the timer pool.
`default_nettype none
package tpa_pkg;

  localparam int NUM_TIMERS_DEFAULT = 8;
  localparam int COUNT_BITS_DEFAULT = 16;

  // Request codes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_STOP    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // Owners and timeout destinations.
  localparam logic [1:0] OWNER_APP     = 2'd1;
  localparam logic [1:0] OWNER_DISPLAY = 2'd2;
  localparam logic [1:0] DEST_READ     = 2'd0;
  localparam logic [1:0] DEST_SEND     = 2'd1;
  localparam logic [1:0] DEST_UNKNOWN  = 2'd2;

  typedef struct packed {
    logic capture;
    logic idx_clear;
    logic idx_inc;
    logic start_claim;
    logic start_fail;
    logic stop_exec;
    logic tick_expire;
    logic tick_dec;
    logic push_last;
  } tpa_cmd_t;

  typedef struct packed {
    logic cur_running;
    logic idx_last;
    logic expire;
    logic hold_valid;
    logic out_free;
  } tpa_status_t;

endpackage
`default_nettype wire

FILE: sv/tpa_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
`default_nettype none
module tpa_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/tpa_datapath.sv
// Datapath of the timer pool: timer store, running bits, walk index and result registers.
`default_nettype none
module tpa_datapath #(
  parameter int NUM_TIMERS = tpa_pkg::NUM_TIMERS_DEFAULT,
  parameter int COUNT_BITS = tpa_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tpa_pkg::tpa_cmd_t    cmd,
  output tpa_pkg::tpa_status_t      status,
  input  wire logic [1:0]           owner,
  input  wire logic [15:0]          start_count,
  input  wire logic [6:0]           timer_index,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic [1:0]                kind,
  output logic [5:0]                slot,
  output logic                      failed,
  output logic [1:0]                destination,
  output logic                      last
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int DW = COUNT_BITS + 2;

  logic [NUM_TIMERS-1:0] running;
  logic [IW-1:0]         idx;
  logic [1:0]            req_owner;
  logic [COUNT_BITS-1:0] req_count;
  logic [6:0]            req_index;

  logic                  hold_valid;
  logic [1:0]            hold_kind;
  logic [5:0]            hold_slot;
  logic                  hold_failed;
  logic [1:0]            hold_dest;

  logic                  ram_we;
  logic [DW-1:0]         ram_wdata;
  logic [DW-1:0]         ram_rdata;
  logic [COUNT_BITS-1:0] cur_rem;
  logic [1:0]            cur_owner;
  logic                  stop_bad;
  logic [IW-1:0]         stop_slot;
  logic                  out_load;

  function automatic logic [1:0] owner_dest(input logic [1:0] own);
    logic [1:0] d;
    d = tpa_pkg::DEST_UNKNOWN;
    if (own == tpa_pkg::OWNER_APP) begin
      d = tpa_pkg::DEST_READ;
    end else if (own == tpa_pkg::OWNER_DISPLAY) begin
      d = tpa_pkg::DEST_SEND;
    end
    return d;
  endfunction

  assign cur_rem   = ram_rdata[COUNT_BITS-1:0];
  assign cur_owner = ram_rdata[DW-1:COUNT_BITS];
  assign stop_bad  = req_index >= 7'(NUM_TIMERS);
  assign stop_slot = req_index[IW-1:0];

  assign ram_we    = cmd.start_claim || cmd.tick_dec;
  assign ram_wdata = cmd.start_claim ? {req_owner, req_count}
                                     : {cur_owner, cur_rem - COUNT_BITS'(1)};

  tpa_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_TIMERS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // A count of zero or one both expire on this tick.
  assign status.cur_running = running[idx];
  assign status.idx_last    = idx == IW'(NUM_TIMERS - 1);
  assign status.expire      = running[idx] && (cur_rem[COUNT_BITS-1:1] == '0);
  assign status.hold_valid  = hold_valid;
  assign status.out_free    = !rsp_valid || !rsp_stall;

  // The held result goes out early once a later timeout shows it is not the last.
  assign out_load = cmd.push_last || (cmd.tick_expire && hold_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= '0;
      idx        <= '0;
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end

      if (cmd.start_claim) begin
        running[idx] <= 1'b1;
      end else if (cmd.tick_expire) begin
        running[idx] <= 1'b0;
      end else if (cmd.stop_exec && !stop_bad) begin
        running[stop_slot] <= 1'b0;
      end

      if (cmd.start_claim || cmd.start_fail || cmd.stop_exec || cmd.tick_expire) begin
        hold_valid <= 1'b1;
      end else if (cmd.push_last) begin
        hold_valid <= 1'b0;
      end

      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_owner <= owner;
      req_count <= COUNT_BITS'(start_count);
      req_index <= timer_index;
    end

    if (cmd.start_claim) begin
      hold_kind   <= tpa_pkg::KIND_START;
      hold_slot   <= 6'(idx);
      hold_failed <= 1'b0;
      hold_dest   <= tpa_pkg::DEST_READ;
    end else if (cmd.start_fail) begin
      hold_kind   <= tpa_pkg::KIND_START;
      hold_slot   <= '0;
      hold_failed <= 1'b1;
      hold_dest   <= tpa_pkg::DEST_READ;
    end else if (cmd.stop_exec) begin
      hold_kind   <= tpa_pkg::KIND_STOP;
      hold_slot   <= stop_bad ? 6'd0 : 6'(stop_slot);
      hold_failed <= stop_bad;
      hold_dest   <= tpa_pkg::DEST_READ;
    end else if (cmd.tick_expire) begin
      hold_kind   <= tpa_pkg::KIND_TIMEOUT;
      hold_slot   <= 6'(idx);
      hold_failed <= 1'b0;
      hold_dest   <= owner_dest(cur_owner);
    end

    if (out_load) begin
      kind        <= hold_kind;
      slot        <= hold_slot;
      failed      <= hold_failed;
      destination <= hold_dest;
      last        <= cmd.push_last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!rsp_valid || !rsp_stall))
    else $error("result register loaded while a stalled item waits");

  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start_claim |-> !running[idx])
    else $error("start claimed a running timer");

  a_claim_sets: assert property (@(posedge clk) disable iff (rst)
    cmd.start_claim |=> running[$past(idx)])
    else $error("claimed timer not marked running");

  a_tick_running: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick_expire || cmd.tick_dec) |-> running[idx])
    else $error("tick acted on a stopped timer");

endmodule
`default_nettype wire

FILE: sv/tpa_ctrl.sv
// Controller state machine of the timer pool: sequences start, stop and tick walks.
`default_nettype none
module tpa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic [1:0]           op,
  input  wire tpa_pkg::tpa_status_t status,
  output tpa_pkg::tpa_cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_STOP  = 3'd2;
  localparam logic [2:0] ST_TRD   = 3'd3;
  localparam logic [2:0] ST_TEV   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = state != ST_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture   = 1'b1;
          cmd.idx_clear = 1'b1;
          case (op)
            tpa_pkg::OP_START: state_next = ST_SCAN;
            tpa_pkg::OP_STOP:  state_next = ST_STOP;
            tpa_pkg::OP_TICK:  state_next = ST_TRD;
            default:           state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!status.cur_running) begin
          cmd.start_claim = 1'b1;
          state_next      = ST_FLUSH;
        end else if (status.idx_last) begin
          cmd.start_fail = 1'b1;
          state_next     = ST_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_STOP: begin
        cmd.stop_exec = 1'b1;
        state_next    = ST_FLUSH;
      end
      ST_TRD: begin
        // Stopped timers are skipped on their running bit, without waiting for the store read.
        if (status.cur_running) begin
          state_next = ST_TEV;
        end else if (status.idx_last) begin
          state_next = ST_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_TEV: begin
        if (status.expire) begin
          // An earlier timeout still held must leave before this one replaces it.
          if (!status.hold_valid || status.out_free) begin
            cmd.tick_expire = 1'b1;
            cmd.idx_inc     = !status.idx_last;
            state_next      = status.idx_last ? ST_FLUSH : ST_TRD;
          end
        end else begin
          cmd.tick_dec = 1'b1;
          cmd.idx_inc  = !status.idx_last;
          state_next   = status.idx_last ? ST_FLUSH : ST_TRD;
        end
      end
      ST_FLUSH: begin
        if (!status.hold_valid) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.push_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (state == ST_IDLE))
    else $error("item captured outside idle");

  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    cmd.push_last |=> (state == ST_IDLE))
    else $error("controller did not return to idle after the last result");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start_claim, cmd.start_fail, cmd.stop_exec, cmd.tick_expire,
              cmd.tick_dec, cmd.push_last}))
    else $error("more than one datapath action in a cycle");

endmodule
`default_nettype wire

FILE: sv/timer_pool_allocator.sv
// Top level of the timer pool: start, stop and tick requests over a pool of countdown timers.
// A stop passes through the stop and flush states; a start scans the timers in order for a free one, then flushes.
// A tick walks the timers one at a time: a stopped timer needs only its running bit, a running one a store read too.
// The walk through the single-port timer store sets the rate; one item is handled at a time.
// A timeout waits in place while an earlier timeout is held and the result register is stalled, then the walk resumes.
// Reset clears all running bits together; the timer store needs no clearing pass.
`default_nettype none
module timer_pool_allocator #(
  parameter int NUM_TIMERS = tpa_pkg::NUM_TIMERS_DEFAULT,
  parameter int COUNT_BITS = tpa_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  op,
  input  wire logic [1:0]  owner,
  input  wire logic [15:0] start_count,
  input  wire logic [6:0]  timer_index,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [1:0]       kind,
  output logic [5:0]       slot,
  output logic             failed,
  output logic [1:0]       destination,
  output logic             last
);

  tpa_pkg::tpa_cmd_t    cmd;
  tpa_pkg::tpa_status_t status;

  tpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .status    (status),
    .cmd       (cmd)
  );

  tpa_datapath #(
    .NUM_TIMERS (NUM_TIMERS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .owner       (owner),
    .start_count (start_count),
    .timer_index (timer_index),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .kind        (kind),
    .slot        (slot),
    .failed      (failed),
    .destination (destination),
    .last        (last)
  );

endmodule
`default_nettype wire

FILE: tb/tpa_result_checker.sv
// Scoreboard for the timer pool: predicts each request's results and checks what comes out.
`timescale 1ns / 1ps
module tpa_result_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_stall,
  input  wire logic [1:0]  op,
  input  wire logic [1:0]  owner,
  input  wire logic [15:0] start_count,
  input  wire logic [6:0]  timer_index,
  input  wire logic        rsp_valid,
  input  wire logic        rsp_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [5:0]  slot,
  input  wire logic        failed,
  input  wire logic [1:0]  destination,
  input  wire logic        last,
  output int               fail_count,
  output int               outstanding
);

  localparam int TIMERS = tpa_pkg::NUM_TIMERS_DEFAULT;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] slot;
    logic       failed;
    logic [1:0] destination;
    logic       last;
  } pool_result_t;

  pool_result_t due_results[$];

  // Shadow copy of the timer pool.
  logic [15:0] ticks_left [TIMERS];
  logic [1:0]  held_by    [TIMERS];
  logic        armed      [TIMERS];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] timer pool mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic clear_timer(input int t);
    ticks_left[t] = '0;
    held_by[t]    = '0;
    armed[t]      = 1'b0;
  endtask

  task automatic apply_request(input logic [1:0] req_op, input logic [1:0] req_owner,
                               input logic [15:0] req_count, input logic [6:0] req_index);
    pool_result_t r;
    int t;
    int fired;
    bit claimed;
    r = '0;
    fired = 0;
    claimed = 1'b0;
    case (req_op)
      tpa_pkg::OP_START: begin
        r.kind = tpa_pkg::KIND_START;
        r.last = 1'b1;
        for (t = 0; t < TIMERS; t++) begin
          if (!claimed && !armed[t]) begin
            ticks_left[t] = req_count;
            held_by[t]    = req_owner;
            armed[t]      = 1'b1;
            r.slot        = t[5:0];
            claimed       = 1'b1;
          end
        end
        r.failed = !claimed;
        due_results.push_back(r);
      end
      tpa_pkg::OP_STOP: begin
        r.kind = tpa_pkg::KIND_STOP;
        r.last = 1'b1;
        if (req_index >= TIMERS) begin
          r.failed = 1'b1;
        end else begin
          clear_timer(int'(req_index));
          r.slot = req_index[5:0];
        end
        due_results.push_back(r);
      end
      tpa_pkg::OP_TICK: begin
        for (t = 0; t < TIMERS; t++) begin
          if (armed[t]) begin
            // A count of zero expires on the first tick, same as a count of one.
            if (ticks_left[t] <= 16'd1) begin
              r = '0;
              r.kind = tpa_pkg::KIND_TIMEOUT;
              r.slot = t[5:0];
              if (held_by[t] == tpa_pkg::OWNER_APP) r.destination = tpa_pkg::DEST_READ;
              else if (held_by[t] == tpa_pkg::OWNER_DISPLAY) r.destination = tpa_pkg::DEST_SEND;
              else r.destination = tpa_pkg::DEST_UNKNOWN;
              due_results.push_back(r);
              fired++;
              clear_timer(t);
            end else begin
              ticks_left[t] = ticks_left[t] - 16'd1;
            end
          end
        end
        if (fired > 0) begin
          r = due_results.pop_back();
          r.last = 1'b1;
          due_results.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    int t;
    pool_result_t want;
    if (rst) begin
      due_results.delete();
      for (t = 0; t < TIMERS; t++) clear_timer(t);
    end else begin
      // Results are checked before the new request is predicted; a request
      // can never produce its result on the edge where it is accepted.
      if (rsp_valid && !rsp_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d slot %0d", kind, slot));
        end else begin
          want = due_results.pop_front();
          check_field("kind", kind, want.kind);
          check_field("slot", slot, want.slot);
          check_field("failed", failed, want.failed);
          check_field("destination", destination, want.destination);
          check_field("last", last, want.last);
        end
      end
      if (req_valid && !req_stall) begin
        apply_request(op, owner, start_count, timer_index);
      end
    end
    outstanding <= due_results.size();
  end

endmodule

FILE: tb/tb_top.sv
// Top of the timer pool testbench: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [1:0] OWNER_NONE     = 2'd0;
  localparam logic [1:0] OWNER_RESERVED = 2'd3;
  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 22;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic [1:0]  op = tpa_pkg::OP_TICK;
  logic [1:0]  owner = '0;
  logic [15:0] start_count = '0;
  logic [6:0]  timer_index = '0;
  logic        rsp_stall = 1'b0;
  logic        req_stall;
  logic        rsp_valid;
  logic [1:0]  kind;
  logic [5:0]  slot;
  logic        failed;
  logic [1:0]  destination;
  logic        last;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  timer_pool_allocator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .op(op), .owner(owner), .start_count(start_count), .timer_index(timer_index),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .kind(kind), .slot(slot), .failed(failed), .destination(destination), .last(last)
  );

  tpa_result_checker result_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .op(op), .owner(owner), .start_count(start_count), .timer_index(timer_index),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .kind(kind), .slot(slot), .failed(failed), .destination(destination), .last(last),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** timer_pool_allocator: FAILED **");
      $finish;
    end
  end

  // Response side: random stalls, plus one long hold-off that fills the block up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_stall = 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rsp_stall = 1'b1;
    end else begin
      rsp_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input logic [1:0] o, input logic [1:0] who,
                          input logic [15:0] cnt, input logic [6:0] idx);
    int gap;
    gap = 0;
    while (gap < 50 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid   = 1'b1;
    op          = o;
    owner       = who;
    start_count = cnt;
    timer_index = idx;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Unused fields carry random noise; the block must ignore them.
  task automatic random_request(output bit counted);
    int pick;
    logic [1:0]  who;
    logic [15:0] cnt;
    logic [6:0]  idx;
    pick = $urandom_range(99);
    who  = 2'($urandom_range(3));
    cnt  = 16'($urandom_range(65535));
    idx  = 7'($urandom_range(127));
    counted = 1'b1;
    if (pick < 35) begin
      if ($urandom_range(3) != 0) cnt = 16'($urandom_range(6));
      send_req(tpa_pkg::OP_START, who, cnt, idx);
    end else if (pick < 55) begin
      if ($urandom_range(4) != 0) idx = 7'($urandom_range(9));
      send_req(tpa_pkg::OP_STOP, who, cnt, idx);
    end else if (pick < 95) begin
      send_req(tpa_pkg::OP_TICK, who, cnt, idx);
    end else begin
      counted = 1'b0;
      send_req(OP_UNUSED, who, cnt, idx);
    end
  endtask

  initial begin : stimulus
    int i;
    int ph;
    int counted_items;
    bit counted;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty tick, unused op, every owner, zero and full counts.
    send_req(tpa_pkg::OP_TICK, OWNER_NONE, 16'd0, 7'd0);
    send_req(OP_UNUSED, OWNER_RESERVED, 16'hFFFF, 7'h7F);
    send_req(tpa_pkg::OP_START, tpa_pkg::OWNER_APP, 16'd0, 7'd0);
    send_req(tpa_pkg::OP_START, tpa_pkg::OWNER_DISPLAY, 16'd1, 7'd0);
    send_req(tpa_pkg::OP_START, OWNER_NONE, 16'hFFFF, 7'd0);
    send_req(tpa_pkg::OP_START, OWNER_RESERVED, 16'd2, 7'd0);
    send_req(tpa_pkg::OP_TICK, OWNER_NONE, 16'd0, 7'd0);
    send_req(tpa_pkg::OP_TICK, OWNER_NONE, 16'd0, 7'd0);
    // Out-of-range stops, a stop of an idle timer and of a running one.
    send_req(tpa_pkg::OP_STOP, OWNER_NONE, 16'd0, 7'h7F);
    send_req(tpa_pkg::OP_STOP, OWNER_NONE, 16'd0, 7'(tpa_pkg::NUM_TIMERS_DEFAULT));
    send_req(tpa_pkg::OP_STOP, OWNER_NONE, 16'd0, 7'(tpa_pkg::NUM_TIMERS_DEFAULT - 1));
    send_req(tpa_pkg::OP_STOP, OWNER_NONE, 16'd0, 7'd2);
    // Fill the pool, overflow it, then expire every timer on one tick.
    for (i = 0; i < tpa_pkg::NUM_TIMERS_DEFAULT; i++) begin
      send_req(tpa_pkg::OP_START, 2'(i % 4), (i % 2 == 1) ? 16'd0 : 16'd1, 7'd0);
    end
    send_req(tpa_pkg::OP_START, tpa_pkg::OWNER_APP, 16'd5, 7'd0);
    send_req(tpa_pkg::OP_TICK, OWNER_NONE, 16'd0, 7'd0);
    drain_results();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  hold_request = 1'b1; end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) begin
        random_request(counted);
        if (counted) counted_items++;
      end
      // The sender waits here until every pending result has come back.
      drain_results();
    end

    stall_pct = 0;
    drain_results();
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("** timer_pool_allocator: PASSED **");
    end else begin
      $display("** timer_pool_allocator: FAILED **");
    end
    $finish;
  end

endmodule
